// ===== rtl/mme_pkg.sv =====
// mme_pkg: sizes, state and tag types and the dimension clamp for the matrix multiply engine
// no dependencies; imported by matrix_multiply_engine
package mme_pkg;

    // largest matrix dimension and operand width
    localparam int MAX_DIM      = 8;
    localparam int OPERAND_BITS = 16;

    // widths that follow from the sizes
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int MUL_W       = 2 * OPERAND_BITS;

    // fixed field widths of the ports
    localparam int CFG_BITS     = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int PRODUCT_BITS = 35;
    localparam int ROW_BITS     = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLS_B    = 2'd2;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_LOAD_A,
        ST_LOAD_B,
        ST_COMPUTE
    } t_state;

    // control that travels with each multiply through the pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_res;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // zero reads as one, anything above the largest size as the largest size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_BITS-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > CFG_BITS'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

endpackage

// ===== rtl/matrix_multiply_engine.sv =====
// matrix_multiply_engine: loads A then B into two stores, then runs one shared MAC over them
// depends on mme_pkg
//
// channel   direction  handshake                   payload
// operand   in         i_in_valid / o_in_stall     i_operand_value
// result    out        o_out_valid / i_out_stall   o_product_value, o_out_row, o_out_col,
//                                                  o_last_result
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// operand beats: M*K beats of A, then K*N beats of B
// the MAC issues one store read pair per cycle unless the result is stalled, M*N*K pairs per run, and each result
// shows once its last pair has passed the store read, multiply and output registers
// operand beats are stalled during the MAC phase; a stalled result freezes the pipeline
// reset (synchronous, active low) restores 8x8x8 and the load of A; stores need no clear
module matrix_multiply_engine
    import mme_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_BITS-1:0]            i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [OPERAND_BITS-1:0] i_operand_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [PRODUCT_BITS-1:0] o_product_value,
    output logic [ROW_BITS-1:0]            o_out_row,
    output logic [ROW_BITS-1:0]            o_out_col,
    output logic                           o_last_result
);

    // configuration
    logic [CFG_BITS-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic [DIM_W-1:0]    w_m, w_k, w_n, w_m_m1, w_k_m1, w_n_m1;
    logic [CNT_W-1:0]    w_total_a, w_total_b;
    logic                w_cfg_hit;

    // control
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_load_cnt, w_cnt_inc;
    logic                w_in_accept, w_load_end, w_adv, w_issue;
    logic                w_last_t, w_last_c, w_last_r;
    logic [IDX_W-1:0]    r_t, r_c, r_r;
    logic [ADDR_W-1:0]   r_a_addr, r_b_addr, r_row_base;

    // stores and datapath
    logic [OPERAND_BITS-1:0]        r_a_mem [STORE_DEPTH];
    logic [OPERAND_BITS-1:0]        r_b_mem [STORE_DEPTH];
    logic [OPERAND_BITS-1:0]        r_a_rd, r_b_rd;
    logic signed [MUL_W-1:0]        r_prod;
    logic signed [PRODUCT_BITS-1:0] r_acc, w_acc_next, w_prod_ext;
    t_tag                           r_s1, r_s2, w_tag;

    // output register
    logic                           r_out_valid, r_out_last;
    logic signed [PRODUCT_BITS-1:0] r_out_value;
    logic [IDX_W-1:0]               r_out_row, r_out_col;

    // effective sizes and phase lengths
    assign w_m       = eff_dim(r_rows_a);
    assign w_k       = eff_dim(r_inner_dim);
    assign w_n       = eff_dim(r_cols_b);
    assign w_m_m1    = w_m - DIM_W'(1);
    assign w_k_m1    = w_k - DIM_W'(1);
    assign w_n_m1    = w_n - DIM_W'(1);
    assign w_total_a = CNT_W'(w_m) * CNT_W'(w_k);
    assign w_total_b = CNT_W'(w_k) * CNT_W'(w_n);

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == REG_ROWS_A ||
                                    i_cfg_index == REG_INNER_DIM ||
                                    i_cfg_index == REG_COLS_B);

    // handshake and pipeline advance
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_cnt_inc   = r_load_cnt + CNT_W'(1);
    assign w_load_end  = (r_state == ST_LOAD_A) ? (w_cnt_inc == w_total_a)
                                                : (w_cnt_inc == w_total_b);
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_last_t    = (r_t == w_k_m1[IDX_W-1:0]);
    assign w_last_c    = (r_c == w_n_m1[IDX_W-1:0]);
    assign w_last_r    = (r_r == w_m_m1[IDX_W-1:0]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET;
            r_inner_dim <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (w_cfg_hit) begin
            n_state = ST_LOAD_A;
        end else begin
            case (r_state)
                ST_LOAD_A: begin
                    if (w_in_accept && w_load_end) n_state = ST_LOAD_B;
                end
                ST_LOAD_B: begin
                    if (w_in_accept && w_load_end) n_state = ST_COMPUTE;
                end
                ST_COMPUTE: begin
                    if (w_issue && w_last_t && w_last_c && w_last_r) n_state = ST_LOAD_A;
                end
                default: n_state = ST_LOAD_A;
            endcase
        end
    end

    // state outputs
    always_comb begin
        case (r_state)
            ST_LOAD_A, ST_LOAD_B: begin
                o_in_stall = 1'b0;
                w_issue    = 1'b0;
            end
            ST_COMPUTE: begin
                o_in_stall = 1'b1;
                w_issue    = w_adv;
            end
            default: begin
                o_in_stall = 1'b1;
                w_issue    = 1'b0;
            end
        endcase
    end

    // state and load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD_A;
            r_load_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_hit) begin
                r_load_cnt <= '0;
            end else if (w_in_accept) begin
                r_load_cnt <= w_load_end ? '0 : w_cnt_inc;
            end
        end
    end

    // loop counters and store addresses of the MAC phase
    always_ff @(posedge i_clk) begin
        if (w_in_accept && r_state == ST_LOAD_B && w_load_end) begin
            r_t        <= '0;
            r_c        <= '0;
            r_r        <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
            r_row_base <= '0;
        end else if (w_issue) begin
            if (!w_last_t) begin
                r_t      <= r_t + IDX_W'(1);
                r_a_addr <= r_a_addr + ADDR_W'(1);
                r_b_addr <= r_b_addr + ADDR_W'(w_n);
            end else if (!w_last_c) begin
                r_t      <= '0;
                r_c      <= r_c + IDX_W'(1);
                r_a_addr <= r_row_base;
                r_b_addr <= ADDR_W'(r_c) + ADDR_W'(1);
            end else begin
                r_t        <= '0;
                r_c        <= '0;
                r_r        <= r_r + IDX_W'(1);
                r_row_base <= r_row_base + ADDR_W'(w_k);
                r_a_addr   <= r_row_base + ADDR_W'(w_k);
                r_b_addr   <= '0;
            end
        end
    end

    // operand stores: written on load beats, read on issue
    always_ff @(posedge i_clk) begin
        if (w_in_accept && r_state == ST_LOAD_A) begin
            r_a_mem[r_load_cnt[ADDR_W-1:0]] <= i_operand_value;
        end
        if (w_issue) begin
            r_a_rd <= r_a_mem[r_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && r_state == ST_LOAD_B) begin
            r_b_mem[r_load_cnt[ADDR_W-1:0]] <= i_operand_value;
        end
        if (w_issue) begin
            r_b_rd <= r_b_mem[r_b_addr];
        end
    end

    // tag of the pair being issued
    always_comb begin
        w_tag.valid    = w_issue;
        w_tag.first    = (r_t == '0);
        w_tag.last_k   = w_last_t;
        w_tag.last_res = w_last_c && w_last_r;
        w_tag.row      = r_r;
        w_tag.col      = r_c;
    end

    // pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (w_adv) begin
            r_s1 <= w_tag;
            r_s2 <= r_s1;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1.valid) begin
            r_prod <= $signed(r_a_rd) * $signed(r_b_rd);
        end
    end

    // accumulate stage
    assign w_prod_ext = PRODUCT_BITS'(r_prod);
    assign w_acc_next = r_s2.first ? w_prod_ext : r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2.valid) begin
            r_acc <= w_acc_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s2.valid && r_s2.last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2.valid && r_s2.last_k) begin
            r_out_value <= w_acc_next;
            r_out_row   <= r_s2.row;
            r_out_col   <= r_s2.col;
            r_out_last  <= r_s2.last_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_out_row       = ROW_BITS'(r_out_row);
    assign o_out_col       = ROW_BITS'(r_out_col);
    assign o_last_result   = r_out_last;

    // load counter stays inside the phase being loaded
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD_A) |-> (r_load_cnt < w_total_a))
        else $error("A load count beyond M*K");

    a_load_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD_B) |-> (r_load_cnt < w_total_b))
        else $error("B load count beyond K*N");

    // inner counter never passes K-1 during the MAC phase
    a_inner_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPUTE) |-> (r_t <= w_k_m1[IDX_W-1:0]))
        else $error("inner counter beyond K-1");

    // issue of the final pair ends the MAC phase
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_last_t && w_last_c && w_last_r) |=> (r_state == ST_LOAD_A))
        else $error("MAC phase did not end after final issue");

    // a stalled result freezes the accumulator and the output register
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_acc) && $stable(r_out_valid) && $stable(r_out_value)))
        else $error("pipeline moved under output stall");

endmodule
